// ===== hw/rtl/ctw_pkg.sv =====
// Shared types and constants of the text console character writer.
// Used by the top level and the port checker.
package ctw_pkg;

	localparam int IN_W  = 48;
	localparam int OUT_W = 32;
	localparam int CFG_W = 16;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] ERROR_CHAR   = 8'h45;

	localparam logic [7:0]  DEFAULT_ATTR_RST = 8'h0F;
	localparam logic [7:0]  CLEAR_ATTR_RST   = 8'h07;
	localparam logic [15:0] ERROR_CELL_RST   = 16'h00F4;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_DEFAULT_ATTR = 2'd0,
		CFG_CLEAR_ATTR   = 2'd1,
		CFG_ERROR_CELL   = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_ERR,
		ST_CLEAR,
		ST_PRIME,
		ST_SCROLL,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/ctw_cell_ram.sv =====
// Cell store of the console: one write port, one read port, registered read.
// Depends on nothing beyond its parameters.
module ctw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/text_console_char_writer.sv =====
// Top level of the text console character writer: sequencer, cursor, config and output register.
// Depends on ctw_pkg and ctw_cell_ram.
//
// Keeps a COLUMNS x ROWS screen of 16-bit cells (character low byte, attribute high byte)
// in one single-port-write, single-port-read memory, plus a cursor. Every request gives one
// result. After reset a sweep over every cell zeroes the store before the first request
// is taken. A clear walks the whole store, one cell a cycle. A put that moves the cursor
// past the bottom row scrolls by streaming the store through the memory, one cell a cycle.
// A result waiting in the output register does not block the next request from being
// taken; only its completion waits.
module text_console_char_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  ctw_pkg::cfg_idx_t          cfg_index,
	input  logic [ctw_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// command[1:0], char_code[9:2], attribute[17:10], use_cursor[18],
	// column[26:19], row_index[32:27], read_address[44:33], zero fill [47:45]
	input  logic [ctw_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// cursor_offset[11:0], cell_value[27:12], position_error[28], zero fill [31:29]
	output logic [ctw_pkg::OUT_W-1:0]  m_axis_tdata
);

	import ctw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);

	localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
	localparam logic [AW-1:0] PREV_CELL  = AW'(CELLS - 2);
	localparam logic [AW-1:0] BOTTOM_ROW = AW'(COLUMNS * (ROWS - 1));
	localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
	localparam logic [AW:0]   SCROLL_AHEAD = (AW + 1)'(COLUMNS + 1);
	localparam logic [AW:0]   CELLS_X    = (AW + 1)'(CELLS);
	localparam logic [7:0]    COL_LIM    = 8'(COLUMNS);
	localparam logic [5:0]    ROW_LIM    = 6'(ROWS);
	localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

	state_t state_q, state_d;

	logic [7:0]  dflt_attr_q;
	logic [7:0]  clr_attr_q;
	logic [15:0] err_cell_q;

	cmd_t        cmd_q;
	logic [7:0]  char_q;
	logic [7:0]  attr_q;
	logic        use_cur_q;
	logic [7:0]  in_col_q;
	logic [5:0]  in_row_q;
	logic [11:0] raddr_q;
	logic        err_q;
	logic        rd_ok_q;

	logic [RW-1:0] cur_row_q, cur_row_d;
	logic [CW-1:0] cur_col_q, cur_col_d;
	logic [AW-1:0] idx_q;

	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic          in_accept;
	logic          slot_free;
	logic          out_load;
	logic          idx_last;
	logic          scroll_need;
	logic [RW-1:0] row_sel;
	logic [CW-1:0] col_sel;
	logic [AW-1:0] put_pos;
	logic [AW-1:0] cur_offset;
	logic [AW:0]   scroll_rd;
	logic [7:0]    put_attr;
	logic [RW-1:0] row_n;
	logic [CW-1:0] col_n;
	logic          row_inc;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	cmd_t          in_cmd;
	logic [7:0]    in_col;
	logic [5:0]    in_row;
	logic [11:0]   in_raddr;

	assign in_cmd   = cmd_t'(s_axis_tdata[1:0]);
	assign in_col   = s_axis_tdata[26:19];
	assign in_row   = s_axis_tdata[32:27];
	assign in_raddr = s_axis_tdata[44:33];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign idx_last      = (idx_q == LAST_CELL);

	ctw_cell_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_cell_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Cursor arithmetic for a put
	always_comb begin
		row_sel  = use_cur_q ? cur_row_q : in_row_q[RW-1:0];
		col_sel  = use_cur_q ? cur_col_q : in_col_q[CW-1:0];
		put_pos  = AW'(row_sel) * COLS_A + AW'(col_sel);
		put_attr = (attr_q == 8'h00) ? dflt_attr_q : attr_q;
		if (char_q == NEWLINE_CODE) begin
			col_n   = '0;
			row_inc = 1'b1;
		end else if (col_sel == LAST_COL) begin
			col_n   = '0;
			row_inc = 1'b1;
		end else begin
			col_n   = col_sel + CW'(1);
			row_inc = 1'b0;
		end
		scroll_need = row_inc && (row_sel == LAST_ROW);
		if (scroll_need) begin
			row_n = LAST_ROW;
		end else if (row_inc) begin
			row_n = row_sel + RW'(1);
		end else begin
			row_n = row_sel;
		end
		scroll_rd = {1'b0, idx_q} + SCROLL_AHEAD;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (idx_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_accept) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_PUT: begin
						if (err_q) state_d = ST_ERR;
						else if (scroll_need) state_d = ST_PRIME;
						else state_d = slot_free ? ST_IDLE : ST_DONE;
					end
					CMD_READ:  state_d = ST_DONE;
					CMD_CLEAR: state_d = ST_CLEAR;
					default:   state_d = slot_free ? ST_IDLE : ST_DONE;
				endcase
			end
			ST_ERR:    state_d = ST_DONE;
			ST_CLEAR: begin
				if (idx_last) state_d = ST_DONE;
			end
			ST_PRIME:  state_d = ST_SCROLL;
			ST_SCROLL: begin
				if (idx_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory accesses, cursor update and result load
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		cur_row_d = cur_row_q;
		cur_col_d = cur_col_q;
		out_load  = 1'b0;
		case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_PUT: begin
						if (err_q) begin
							ram_we    = 1'b1;
							ram_waddr = PREV_CELL;
							ram_wdata = {8'h00, ERROR_CHAR};
						end else begin
							ram_we    = (char_q != NEWLINE_CODE);
							ram_waddr = put_pos;
							ram_wdata = {put_attr, char_q};
							cur_row_d = row_n;
							cur_col_d = col_n;
							out_load  = !scroll_need && slot_free;
						end
					end
					CMD_READ: begin
						ram_re    = rd_ok_q;
						ram_raddr = raddr_q[AW-1:0];
					end
					CMD_CLEAR: begin
						cur_row_d = '0;
						cur_col_d = '0;
					end
					default: begin
						out_load = slot_free;
					end
				endcase
			end
			ST_ERR: begin
				ram_we    = 1'b1;
				ram_waddr = LAST_CELL;
				ram_wdata = err_cell_q;
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = {clr_attr_q, BLANK_CODE};
			end
			ST_PRIME: begin
				ram_re    = 1'b1;
				ram_raddr = COLS_A;
			end
			ST_SCROLL: begin
				ram_we    = 1'b1;
				ram_wdata = (idx_q < BOTTOM_ROW) ? ram_rdata : 16'h0000;
				ram_re    = (scroll_rd < CELLS_X);
				ram_raddr = scroll_rd[AW-1:0];
			end
			ST_DONE: begin
				out_load = slot_free;
			end
			default: begin
			end
		endcase
		cur_offset = AW'(cur_row_d) * COLS_A + AW'(cur_col_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			idx_q     <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else begin
			state_q   <= state_d;
			cur_row_q <= cur_row_d;
			cur_col_q <= cur_col_d;
			if (state_q == ST_EXEC) begin
				idx_q <= '0;
			end else if (state_q == ST_INIT || state_q == ST_CLEAR ||
				state_q == ST_SCROLL) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_attr_q <= DEFAULT_ATTR_RST;
			clr_attr_q  <= CLEAR_ATTR_RST;
			err_cell_q  <= ERROR_CELL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DEFAULT_ATTR: dflt_attr_q <= cfg_wdata[7:0];
				CFG_CLEAR_ATTR:   clr_attr_q  <= cfg_wdata[7:0];
				CFG_ERROR_CELL:   err_cell_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q     <= in_cmd;
			char_q    <= s_axis_tdata[9:2];
			attr_q    <= s_axis_tdata[17:10];
			use_cur_q <= s_axis_tdata[18];
			in_col_q  <= in_col;
			in_row_q  <= in_row;
			raddr_q   <= in_raddr;
			err_q     <= !s_axis_tdata[18] && ((in_col >= COL_LIM) || (in_row >= ROW_LIM));
			rd_ok_q   <= ({1'b0, in_raddr} < 13'(CELLS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {3'b000,
				(cmd_q == CMD_PUT) && err_q,
				((cmd_q == CMD_READ) && rd_ok_q) ? ram_rdata : 16'h0000,
				12'(cur_offset)};
		end
	end

endmodule

// ===== hw/rtl/ctw_checker.sv =====
// Port checker of the text console character writer and its bind to the top level.
// Depends on ctw_pkg.
module ctw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [ctw_pkg::OUT_W-1:0] m_axis_tdata
);

	import ctw_pkg::*;

	localparam logic [12:0] CELLS_X = 13'(COLUMNS * ROWS);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 2'd0)
		else $error("result without request");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> {1'b0, m_axis_tdata[11:0]} < CELLS_X)
		else $error("cursor outside screen");

	a_err_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[28] |-> m_axis_tdata[27:12] == 16'h0000)
		else $error("cell value on position error");

endmodule

bind text_console_char_writer ctw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_ctw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
